/* src/gamma_dimmer_soft_start_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros for the gamma dimmer
// shared concurrent check forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef GAMMA_DIMMER_SOFT_START_MACROS_SVH
`define GAMMA_DIMMER_SOFT_START_MACROS_SVH

// implication checked every edge outside reset
`define GDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the edge after the trigger
`define GDS_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* src/gds_pkg.sv */
// ---------------------------------------------------------------------------
// gds_pkg
// shared constants, sequencer state codes and the power table
// ---------------------------------------------------------------------------
package gds_pkg;

  localparam int unsigned DUTY_FULL = 4095;

  // reciprocals of 100 for the level fraction and the master scaling
  localparam logic [23:0] X_RECIP = 24'd10737419;
  localparam int unsigned X_SHIFT = 30;
  localparam logic [23:0] M_RECIP = 24'd671089;
  localparam int unsigned M_SHIFT = 26;

  localparam logic [2:0] REG_MIN    = 3'd0;
  localparam logic [2:0] REG_MAX    = 3'd1;
  localparam logic [2:0] REG_GAMMA  = 3'd2;
  localparam logic [2:0] REG_SOFT   = 3'd3;
  localparam logic [2:0] REG_CAP    = 3'd4;
  localparam logic [2:0] REG_MASTER = 3'd5;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_XDIV  = 4'd1;
  localparam logic [3:0] S_NORM  = 4'd2;
  localparam logic [3:0] S_LOG   = 4'd3;
  localparam logic [3:0] S_MAG   = 4'd4;
  localparam logic [3:0] S_POW   = 4'd5;
  localparam logic [3:0] S_DUTY  = 4'd6;
  localparam logic [3:0] S_TGT   = 4'd7;
  localparam logic [3:0] S_RAMP  = 4'd8;
  localparam logic [3:0] S_RDIV  = 4'd9;
  localparam logic [3:0] S_MSTR  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  typedef logic [3:0] state_t;

  function automatic logic [15:0] pow_entry(input logic [3:0] k);
    logic [15:0] v;
    begin
      case (k)
        4'd0:    v = 16'd46341;
        4'd1:    v = 16'd55109;
        4'd2:    v = 16'd60097;
        4'd3:    v = 16'd62757;
        4'd4:    v = 16'd64132;
        4'd5:    v = 16'd64830;
        4'd6:    v = 16'd65181;
        4'd7:    v = 16'd65358;
        4'd8:    v = 16'd65447;
        4'd9:    v = 16'd65492;
        4'd10:   v = 16'd65514;
        4'd11:   v = 16'd65525;
        4'd12:   v = 16'd65530;
        4'd13:   v = 16'd65533;
        default: v = 16'd65535;
      endcase
      return v;
    end
  endfunction

endpackage

/* src/gamma_dimmer_soft_start.sv */
// ---------------------------------------------------------------------------
// gamma_dimmer_soft_start
// gamma corrected pwm dimmer with linear soft-start ramp
// ---------------------------------------------------------------------------
// One item at a time; in_stall is high from acceptance until the item is
// done and while a result waits in the output register. A set item with
// level 0 goes straight to the target update; any other set item runs a
// reciprocal multiply for the level fraction, up to 7 normalize shifts, a
// squaring loop for the log, the gamma product, the power-table steps,
// then the duty and the target. A tick item with the ramp settled goes
// straight to the master scaling; one with a ramp still running first
// runs a 44-step restoring divider for the ramp step. The master scaling
// is a product and then a reciprocal multiply.
// One shared 24x24 multiplier and one restoring divider carry the
// arithmetic. Configuration writes go straight into the registers.
// ---------------------------------------------------------------------------
`include "gamma_dimmer_soft_start_macros.svh"

module gamma_dimmer_soft_start import gds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_level_percent,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_duty_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [11:0] min_r, max_r, gamma_r;
  logic [15:0] soft_r;
  logic [6:0]  cap_r, master_r;

  logic [6:0]  level_r;
  logic [11:0] target_r, current_r, origin_r;
  logic [31:0] start_r;

  state_t      state_r;
  logic [31:0] now_r;
  logic [5:0]  cnt_r;
  logic [34:0] x_r;
  logic [4:0]  e_r;
  logic [15:0] frac_r;
  logic [35:0] mag_r;
  logic [16:0] r_r;
  logic [11:0] newt_r;

  // restoring divider for the ramp step
  logic [43:0] dq_r;
  logic [16:0] drem_r;
  logic [16:0] dden_r;

  logic        out_valid_r;
  logic [11:0] out_duty_r;

  // shared multiplier
  logic [23:0] ma, mb;
  logic [47:0] mp;

  logic [11:0] mx_c, mn_c;
  logic [6:0]  cap_c, mst_c;
  logic [31:0] elapsed;
  logic [17:0] drem_sh;
  logic [17:0] drem_sub;
  logic [34:0] sq;
  logic [63:0] duty_w;

  always_comb begin
    mx_c  = (max_r > 12'(DUTY_FULL)) ? 12'(DUTY_FULL) : max_r;
    mn_c  = (min_r > 12'(DUTY_FULL)) ? 12'(DUTY_FULL) : min_r;
    if (mn_c > mx_c) mn_c = mx_c;
    cap_c = (cap_r > 7'd100) ? 7'd100 : cap_r;
    mst_c = (master_r > 7'd100) ? 7'd100 : master_r;
  end

  assign elapsed  = now_r - start_r;
  assign drem_sh  = {drem_r, dq_r[43]};
  assign drem_sub = drem_sh - {1'b0, dden_r};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_XDIV:  begin ma = 24'(x_r); mb = X_RECIP; end
      S_LOG:   begin ma = 24'(x_r); mb = 24'(x_r); end
      S_MAG:   begin ma = 24'({e_r, 16'd0} - {5'd0, frac_r}); mb = 24'(gamma_r); end
      S_POW:   begin ma = 24'(r_r); mb = 24'(pow_entry(cnt_r[3:0])); end
      S_DUTY:  begin ma = 24'(r_r); mb = 24'(mx_c - mn_c); end
      S_RAMP:  begin
        ma = 24'((target_r >= origin_r) ? target_r - origin_r : origin_r - target_r);
        mb = 24'(elapsed);
      end
      S_MSTR:  begin ma = 24'(current_r); mb = 24'(mst_c); end
      S_OUT:   begin ma = 24'(x_r); mb = M_RECIP; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mp = 48'(ma) * 48'(mb);
  assign sq = 35'(mp >> 16);
  assign duty_w = {20'd0, mn_c, 16'd0} + 64'(mp);

  assign in_stall     = (state_r != S_IDLE) || out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_duty_out = out_duty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0; max_r <= 12'd4095; gamma_r <= 12'd563; soft_r <= '0;
      cap_r <= 7'd100; master_r <= 7'd100;
      level_r <= 7'd100; target_r <= '0; current_r <= '0; origin_r <= '0;
      start_r <= '0;
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN:    min_r    <= cfg_data[11:0];
          REG_MAX:    max_r    <= cfg_data[11:0];
          REG_GAMMA:  gamma_r  <= cfg_data[11:0];
          REG_SOFT:   soft_r   <= cfg_data;
          REG_CAP:    cap_r    <= cfg_data[6:0];
          REG_MASTER: master_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            now_r <= in_now_time;
            if (in_operation == OP_SET) begin
              level_r <= (in_level_percent > 8'd100) ? 7'd100 : in_level_percent[6:0];
              if (in_level_percent == 8'd0) begin
                newt_r  <= '0;
                state_r <= S_TGT;
              end else begin
                // level*65536+50, divided by 100 next
                x_r     <= {12'd0, (in_level_percent > 8'd100) ? 7'd100 : in_level_percent[6:0],
                            16'd0} + 35'd50;
                state_r <= S_XDIV;
              end
            end else begin
              state_r <= S_RAMP;
            end
          end
        end
        S_XDIV: begin
          x_r     <= 35'(mp >> X_SHIFT);
          e_r     <= '0;
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (x_r < 35'd65536) begin
            x_r <= x_r << 1;
            e_r <= e_r + 5'd1;
          end else begin
            cnt_r   <= 6'd16;
            frac_r  <= '0;
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          if (cnt_r == 6'd0) begin
            state_r <= S_MAG;
          end else begin
            if (sq >= 35'd131072) begin
              x_r <= sq >> 1; frac_r <= {frac_r[14:0], 1'b1};
            end else begin
              x_r <= sq;      frac_r <= {frac_r[14:0], 1'b0};
            end
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_MAG: begin
          mag_r   <= 36'((mp + 48'd128) >> 8);
          r_r     <= 17'd65536;
          cnt_r   <= '0;
          state_r <= S_POW;
        end
        S_POW: begin
          if (mag_r[35:16] > 20'd16) begin
            r_r     <= '0;
            state_r <= S_DUTY;
          end else if (cnt_r == 6'd16) begin
            r_r     <= r_r >> mag_r[20:16];
            state_r <= S_DUTY;
          end else begin
            if (mag_r[6'd15 - cnt_r]) r_r <= 17'((mp + 48'd32768) >> 16);
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_DUTY: begin
          if (68'(duty_w) * 68'd100 > 68'(cap_c) * 68'(DUTY_FULL) * 68'd65536)
            newt_r <= 12'(((40'(cap_c) * 40'(DUTY_FULL) + 40'd50) * 40'(M_RECIP)) >> M_SHIFT);
          else if (((duty_w + 64'd32768) >> 16) > 64'(DUTY_FULL))
            newt_r <= 12'(DUTY_FULL);
          else
            newt_r <= 12'((duty_w + 64'd32768) >> 16);
          state_r <= S_TGT;
        end
        S_TGT: begin
          if (newt_r != target_r) begin
            target_r <= newt_r;
            origin_r <= current_r;
            start_r  <= now_r;
          end
          state_r <= S_IDLE;
        end
        S_RAMP: begin
          if (current_r == target_r) begin
            state_r <= S_MSTR;
          end else if (soft_r == 16'd0 || elapsed >= 32'(soft_r)) begin
            current_r <= target_r;
            state_r   <= S_MSTR;
          end else begin
            dq_r    <= 44'(mp);
            drem_r  <= '0;
            dden_r  <= 17'(soft_r);
            cnt_r   <= 6'd44;
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (cnt_r == 6'd0) begin
            current_r <= (target_r >= origin_r) ? origin_r + dq_r[11:0]
                                                : origin_r - dq_r[11:0];
            state_r <= S_MSTR;
          end else begin
            dq_r <= {dq_r[42:0], !drem_sub[17]};
            drem_r <= drem_sub[17] ? drem_sh[16:0] : drem_sub[16:0];
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_MSTR: begin
          // current*master / 100
          x_r     <= 35'(mp);
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_duty_r  <= 12'(mp >> M_SHIFT);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GDS_ASSERT(a_busy_stall, (state_r != S_IDLE) |-> in_stall, "busy but not stalled")
  `GDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_duty_out),
    "result dropped while stalled")
  `GDS_ASSERT_NEXT(a_set_no_out, in_valid && !in_stall && in_operation == OP_SET, !out_valid,
    "set item gave a result")
  `GDS_ASSERT(a_level_range, level_r <= 7'd100, "level above 100")

endmodule

/* verif/tb_gamma_dimmer_soft_start.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gamma_dimmer_soft_start
// Self-checking bench for the gamma dimmer. A short table of set and tick
// items and a directed ramp run first; random phases follow, each with its
// own register setting and one of four idle and stall patterns. Each duty is
// compared with a typed value or a bench model of gamma and soft-start ramp.
// ---------------------------------------------------------------------------
module tb_gamma_dimmer_soft_start import gds_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 140;

  localparam logic [15:0] POW_STEP [16] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830,
    16'd65181, 16'd65358, 16'd65447, 16'd65492, 16'd65514, 16'd65525,
    16'd65530, 16'd65533, 16'd65535, 16'd65535
  };

  typedef struct {
    logic        op;
    logic [7:0]  lvl;
    logic [31:0] now;
    bit          typed;
    logic [11:0] duty;
  } dim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic [7:0] in_level_percent;
  logic [31:0] in_now_time;
  logic out_valid, out_stall;
  logic [11:0] out_duty_out;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  gamma_dimmer_soft_start dut (.*);

  // mirrored registers and dimmer state
  logic [11:0] m_min, m_max, m_gamma;
  logic [15:0] m_soft;
  logic [6:0] m_cap, m_master;
  logic [6:0] s_level;
  logic [11:0] s_target, s_current, s_origin;
  logic [31:0] s_ramp_t0;

  logic [11:0] duty_expected[$];
  int errors = 0;
  int duties_seen = 0;
  int idle_mode = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] gamma_pow(logic [6:0] lvl, logic [11:0] g);
    logic [63:0] x, e, frac, neg, mag, ip, fp, r;
    x = (64'(lvl) * 65536 + 50) / 100;
    e = 0;
    frac = 0;
    if (x == 0) x = 1;
    while (x < 65536) begin
      x = x << 1;
      e++;
    end
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 16;
      frac = frac << 1;
      if (x >= 131072) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    neg = e * 65536 - frac;
    mag = (neg * 64'(g) + 128) >> 8;
    ip = mag >> 16;
    fp = mag & 64'hFFFF;
    if (ip > 16) return 0;
    r = 65536;
    for (int k = 0; k < 16; k++)
      if (fp[15-k]) r = (r * 64'(POW_STEP[k]) + 32768) >> 16;
    return 32'(r >> ip);
  endfunction

  function automatic logic [11:0] target_for_level();
    logic [63:0] mx, mn, cp, duty, g;
    mx = (m_max > DUTY_FULL) ? DUTY_FULL : m_max;
    mn = (m_min > DUTY_FULL) ? DUTY_FULL : m_min;
    cp = (m_cap > 100) ? 100 : m_cap;
    if (mn > mx) mn = mx;
    if (s_level == 0) return 0;
    g = gamma_pow(s_level, m_gamma);
    duty = mn * 65536 + g * (mx - mn);
    if (duty * 100 > cp * DUTY_FULL * 65536) return 12'((cp * DUTY_FULL + 50) / 100);
    duty = (duty + 32768) >> 16;
    if (duty > DUTY_FULL) duty = DUTY_FULL;
    return 12'(duty);
  endfunction

  // returns 1 and the duty when the item gives a result
  function automatic bit dimmer_step(logic op, logic [7:0] lvl, logic [31:0] now,
                                     output logic [11:0] duty);
    logic [11:0] t;
    logic [31:0] elapsed;
    logic [63:0] delta, ms;
    duty = 0;
    if (op == OP_SET) begin
      s_level = (lvl > 100) ? 7'd100 : lvl[6:0];
      t = target_for_level();
      if (t != s_target) begin
        s_target = t;
        s_origin = s_current;
        s_ramp_t0 = now;
      end
      return 0;
    end
    if (s_current != s_target) begin
      elapsed = now - s_ramp_t0;
      if (m_soft == 0 || elapsed >= m_soft) begin
        s_current = s_target;
      end else if (s_target >= s_origin) begin
        delta = 64'(s_target - s_origin) * elapsed / m_soft;
        s_current = s_origin + 12'(delta);
      end else begin
        delta = 64'(s_origin - s_target) * elapsed / m_soft;
        s_current = s_origin - 12'(delta);
      end
    end
    ms = (m_master > 100) ? 100 : m_master;
    duty = 12'(64'(s_current) * ms / 100);
    return 1;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_MIN:    m_min = val[11:0];
      REG_MAX:    m_max = val[11:0];
      REG_GAMMA:  m_gamma = val[11:0];
      REG_SOFT:   m_soft = val;
      REG_CAP:    m_cap = val[6:0];
      REG_MASTER: m_master = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  // sender holds off until the block has nothing left in flight
  task automatic drain();
    while (duty_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(logic op, logic [7:0] lvl, logic [31:0] now,
                           bit typed, logic [11:0] typed_duty);
    logic [11:0] d;
    bit has;
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(99) < ((idle_mode == 1) ? 77 : 7)) @(negedge clk);
    end
    in_valid = 1;
    in_operation = op;
    in_level_percent = lvl;
    in_now_time = now;
    do @(posedge clk); while (in_stall);
    has = dimmer_step(op, lvl, now, d);
    if (has) duty_expected.push_back(typed ? typed_duty : d);
    @(negedge clk);
    in_valid = 0;
  endtask

  always @(negedge clk) begin
    case (idle_mode)
      2: out_stall <= ($urandom_range(99) < 77);
      3: out_stall <= ($urandom_range(99) < 7);
      default: out_stall <= 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      duties_seen++;
      if (duty_expected.size() == 0) begin
        $error("duty_out: unexpected result %0d", out_duty_out);
        errors++;
      end else begin
        if (out_duty_out !== duty_expected[0]) begin
          $error("duty_out: expected %0d, actual %0d", duty_expected[0], out_duty_out);
          errors++;
        end
        void'(duty_expected.pop_front());
      end
    end
  end

  function automatic logic [15:0] pick_reg(int unsigned wide, int unsigned pc);
    int unsigned r;
    r = $urandom_range(9);
    if (pc == 0) return (r < 2) ? 16'(wide) : 16'($urandom());
    if (r == 0) return 0;
    if (r == 1) return (r == 1 && $urandom_range(1)) ? 16'(pc) : 16'(wide);
    return 16'($urandom_range(pc));
  endfunction

  dim_row_t table_rows[$];

  initial begin
    logic [31:0] now;
    bit is_set;
    rst_n = 0;
    in_valid = 0;
    in_operation = OP_SET;
    in_level_percent = 0;
    in_now_time = 0;
    cfg_we = 0;
    cfg_index = REG_MIN;
    cfg_data = 0;
    m_min = 0; m_max = 4095; m_gamma = 563; m_soft = 0; m_cap = 100; m_master = 100;
    s_level = 100; s_target = 0; s_current = 0; s_origin = 0; s_ramp_t0 = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    table_rows = '{
      '{OP_TICK, 8'd0,   32'd0,          1, 12'd0},
      '{OP_SET,  8'd100, 32'd1,          0, 12'd0},
      '{OP_TICK, 8'd0,   32'd2,          1, 12'd4095},
      '{OP_SET,  8'd0,   32'd3,          0, 12'd0},
      '{OP_TICK, 8'd0,   32'd4,          1, 12'd0},
      '{OP_SET,  8'd255, 32'd5,          0, 12'd0},
      '{OP_TICK, 8'd255, 32'd6,          1, 12'd4095},
      '{OP_SET,  8'd1,   32'd7,          0, 12'd0},
      '{OP_TICK, 8'd0,   32'd8,          0, 12'd0},
      '{OP_SET,  8'd50,  32'hFFFFFFFF,   0, 12'd0},
      '{OP_TICK, 8'd0,   32'h0,          0, 12'd0},
      '{OP_SET,  8'd101, 32'h80000000,   0, 12'd0},
      '{OP_TICK, 8'd170, 32'h55555555,   0, 12'd0},
      '{OP_SET,  8'd99,  32'hAAAAAAAA,   0, 12'd0},
      '{OP_TICK, 8'd85,  32'hAAAAAAAB,   0, 12'd0}
    };
    foreach (table_rows[i])
      send_item(table_rows[i].op, table_rows[i].lvl, table_rows[i].now,
                table_rows[i].typed, table_rows[i].duty);

    // ramp, gamma zero and clamped registers
    drain();
    write_reg(REG_SOFT, 16'd100);
    write_reg(REG_GAMMA, 16'd0);
    write_reg(REG_MIN, 16'hFFFF);
    write_reg(REG_MAX, 16'd2000);
    write_reg(REG_CAP, 16'h007F);
    write_reg(REG_MASTER, 16'h007F);
    send_item(OP_SET, 8'd60, 32'd1000, 0, 0);
    send_item(OP_TICK, 8'd0, 32'd1050, 0, 0);
    send_item(OP_SET, 8'd0, 32'd1060, 0, 0);
    send_item(OP_TICK, 8'd0, 32'd1090, 0, 0);
    send_item(OP_TICK, 8'd0, 32'd1300, 0, 0);

    now = 32'd5000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      idle_mode = p % 4;
      if (p == NUM_PHASES - 1) begin
        write_reg(REG_MIN, 16'd4095);
        write_reg(REG_MAX, 16'd4095);
        write_reg(REG_GAMMA, 16'd4095);
        write_reg(REG_SOFT, 16'd65535);
        write_reg(REG_CAP, 16'd100);
        write_reg(REG_MASTER, 16'd100);
      end else if (p == NUM_PHASES - 2) begin
        write_reg(REG_MIN, 16'd0);
        write_reg(REG_MAX, 16'd0);
        write_reg(REG_GAMMA, 16'd4095);
        write_reg(REG_SOFT, 16'd0);
        write_reg(REG_CAP, 16'd0);
        write_reg(REG_MASTER, 16'd0);
      end else begin
        write_reg(REG_MIN, 16'($urandom_range(1)) ? 16'($urandom_range(800)) : 16'($urandom()));
        write_reg(REG_MAX, 16'($urandom()));
        write_reg(REG_GAMMA, pick_reg(4095, 1200));
        write_reg(REG_SOFT, ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(300)));
        write_reg(REG_CAP, pick_reg(127, 100));
        write_reg(REG_MASTER, pick_reg(127, 100));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(19))
          0:       now = $urandom();
          1:       now = now + $urandom_range(70000);
          default: now = now + $urandom_range(40);
        endcase
        is_set = ($urandom_range(99) < 25);
        send_item(is_set ? OP_SET : OP_TICK, 8'($urandom()), now, 0, 0);
        if (i == ITEMS_PER_PHASE / 2 && p == 2) drain();
      end
    end

    while (duty_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("ran %0d phases of set and tick items, %0d duties compared", NUM_PHASES + 1,
             duties_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/gds_pkg.sv
src/gamma_dimmer_soft_start.sv
verif/tb_gamma_dimmer_soft_start.sv
